// ===== rtl/gbw_pkg.sv =====
`default_nettype none

package gbw_pkg;

    localparam int PIX_W = 8;
    localparam int NUM_CH = 3;
    localparam int RGB_W = NUM_CH * PIX_W;

    localparam int WIDTH_W = 11;
    localparam int HEIGHT_W = 13;
    localparam int ROW_W = 12;
    localparam int DIM_W = 13;
    localparam int HEIGHT_LIMIT = 4096;

    localparam logic [WIDTH_W-1:0] WIDTH_RESET = 11'd640;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    typedef struct packed {
        logic valid;
        logic result;
        logic last;
    } gbw_ctrl_t;

    // exp(-d*d/8) in Q0.24, at whole and at half pixel offsets.
    localparam logic [63:0] EXP_WHOLE [0:3] = '{
        64'd16777216, 64'd14805841, 64'd10175896, 64'd5446765
    };
    localparam logic [63:0] EXP_HALF [0:3] = '{
        64'd16261035, 64'd12664107, 64'd7681169, 64'd3628327
    };

    function automatic logic [63:0] gbw_tap(input int k, input int i);
        int d;
        logic [63:0] v;
        if ((k & 1) != 0) begin
            d = i - (k >> 1);
            if (d < 0) d = -d;
            if (d > 3) d = 3;
            v = EXP_WHOLE[d[1:0]];
        end else begin
            d = 2 * i - (k - 1);
            if (d < 0) d = -d;
            d = (d - 1) >>> 1;
            if (d < 0) d = 0;
            if (d > 3) d = 3;
            v = EXP_HALF[d[1:0]];
        end
        return v;
    endfunction

    // Rounded quotient tap(i)*tap(j) / total in Q0.wb by restoring long division.
    function automatic logic [63:0] gbw_raw_weight(input int k, input int wb, input int i,
                                                   input int j, input logic [63:0] total);
        logic [63:0] rem;
        logic [63:0] q;
        int b;
        rem = gbw_tap(k, i) * gbw_tap(k, j);
        q = '0;
        for (b = 0; b <= wb; b++) begin
            rem = rem << 1;
            q = q << 1;
            if (rem >= total) begin
                rem = rem - total;
                q = q | 64'd1;
            end
        end
        return (q + 64'd1) >> 1;
    endfunction

    // The center weight absorbs the rounding error so the kernel sums to 2^wb.
    function automatic logic [31:0] gbw_weight(input int k, input int wb, input int i,
                                               input int j);
        logic [63:0] total;
        logic [63:0] wsum;
        logic [63:0] w;
        int a;
        int b;
        total = '0;
        for (a = 0; a < k; a++) begin
            for (b = 0; b < k; b++) begin
                total = total + gbw_tap(k, a) * gbw_tap(k, b);
            end
        end
        w = gbw_raw_weight(k, wb, i, j, total);
        if (i == (k >> 1) && j == (k >> 1)) begin
            wsum = '0;
            for (a = 0; a < k; a++) begin
                for (b = 0; b < k; b++) begin
                    wsum = wsum + gbw_raw_weight(k, wb, a, b, total);
                end
            end
            w = w + (64'd1 << wb) - wsum;
        end
        return w[31:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/gaussian_blur_rgb_window.sv =====
// Gaussian blur (sigma 2) over an RGB pixel stream in raster order.
// Pixels enter on the s_ channel, one per transaction; filtered pixels leave on the m_
// channel. A result is produced only once a full KERNEL_SIZE x KERNEL_SIZE window is
// available, so a W x H frame yields (W-K+1) x (H-K+1) results; m_tlast marks the result
// made from the last pixel of the frame.
// Frame geometry is set through the cfg_ channel: index 0 is the image width, index 1
// the image height. Write it only while the block is idle.
// Throughput is one pixel per cycle while s_tready is high. An input transaction reaches its
// result on m_tvalid through the line memory read at the accepting edge, the window shift,
// the multiplier stage, the registered adder tree and the saturation register, then the
// output queue.
// Results wait in an output queue. When the receiver stalls, s_tready drops once every
// queue slot is spoken for by a queued result or a pixel still in the pipeline, and
// nothing is lost. Reset clears the counters, pipeline and queue, and restores a
// 640 x 480 geometry; the line memory is not cleared, since stale lines only feed
// windows that produce no result.
`default_nettype none

module gaussian_blur_rgb_window
    import gbw_pkg::*;
#(
    parameter int KERNEL_SIZE = 5,
    parameter int MAX_WIDTH = 1024,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [RGB_W-1:0]       s_tdata,    // red_in, green_in, blue_in

    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [RGB_W-1:0]       m_tdata,    // red_out, green_out, blue_out
    output logic                   m_tlast,    // frame_done

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int TREE_LVL = $clog2(KERNEL_SIZE * KERNEL_SIZE);
    localparam int LATENCY = TREE_LVL + 4;
    localparam int FIFO_DEPTH = TREE_LVL + 6;
    localparam int RES_W = $clog2(FIFO_DEPTH + 1);

    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [DIM_W-1:0]    eff_width;
    logic [DIM_W-1:0]    eff_height;

    logic                                          s_accept;
    logic [KERNEL_SIZE*KERNEL_SIZE-1:0][RGB_W-1:0] win;
    gbw_ctrl_t                                     win_ctrl;
    logic [RGB_W-1:0]                              filt_rgb;
    gbw_ctrl_t                                     filt_ctrl;

    logic             fifo_push;
    logic             drop;
    logic             pop;
    logic [RES_W-1:0] reserved_reg, reserved_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg <= cfg_data[WIDTH_W-1:0];
                REG_IMAGE_HEIGHT: height_reg <= cfg_data[HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        eff_width = DIM_W'(width_reg);
        if (DIM_W'(width_reg) > DIM_W'(MAX_WIDTH)) begin
            eff_width = DIM_W'(MAX_WIDTH);
        end else if (width_reg == '0) begin
            eff_width = DIM_W'(1);
        end
        eff_height = DIM_W'(height_reg);
        if (DIM_W'(height_reg) > DIM_W'(HEIGHT_LIMIT)) begin
            eff_height = DIM_W'(HEIGHT_LIMIT);
        end else if (height_reg == '0) begin
            eff_height = DIM_W'(1);
        end
    end

    assign s_tready = reserved_reg < RES_W'(FIFO_DEPTH);
    assign s_accept = s_tvalid && s_tready;

    gbw_window #(
        .KERNEL_SIZE (KERNEL_SIZE),
        .MAX_WIDTH   (MAX_WIDTH)
    ) u_window (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_accept),
        .in_pix     (s_tdata),
        .eff_width  (eff_width),
        .eff_height (eff_height),
        .win        (win),
        .win_ctrl   (win_ctrl)
    );

    gbw_filter #(
        .KERNEL_SIZE (KERNEL_SIZE),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_filter (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .win      (win),
        .ctrl_in  (win_ctrl),
        .rgb_out  (filt_rgb),
        .ctrl_out (filt_ctrl)
    );

    assign fifo_push = filt_ctrl.valid && filt_ctrl.result;
    assign drop = filt_ctrl.valid && !filt_ctrl.result;
    assign pop = m_tvalid && m_tready;

    gbw_fifo #(
        .WIDTH (RGB_W + 1),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (fifo_push),
        .push_data ({filt_ctrl.last, filt_rgb}),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  ({m_tlast, m_tdata})
    );

    // Every accepted pixel holds a queue slot until it leaves the pipeline without a
    // result or its result is taken.
    always_comb begin
        reserved_next = reserved_reg;
        if (s_accept) begin
            reserved_next = reserved_next + RES_W'(1);
        end
        if (drop) begin
            reserved_next = reserved_next - RES_W'(1);
        end
        if (pop) begin
            reserved_next = reserved_next - RES_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reserved_reg <= '0;
        end else begin
            reserved_reg <= reserved_next;
        end
    end

    a_reserved_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        reserved_reg <= RES_W'(FIFO_DEPTH))
        else $error("queue reservation exceeds the queue depth");

    a_pipe_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        filt_ctrl.valid |-> $past(s_accept, LATENCY))
        else $error("pixel left the pipeline without a matching input transaction");

    a_out_reserved: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> reserved_reg != '0)
        else $error("result queued without a reservation");

endmodule

`default_nettype wire

// ===== rtl/gbw_ram.sv =====
`default_nettype none

module gbw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/gbw_window.sv =====
`default_nettype none

module gbw_window
    import gbw_pkg::*;
#(
    parameter int KERNEL_SIZE = 5,
    parameter int MAX_WIDTH = 1024
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          in_valid,
    input  logic [RGB_W-1:0]                              in_pix,
    input  logic [DIM_W-1:0]                              eff_width,
    input  logic [DIM_W-1:0]                              eff_height,
    output logic [KERNEL_SIZE*KERNEL_SIZE-1:0][RGB_W-1:0] win,
    output gbw_ctrl_t                                     win_ctrl
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int LINES = KERNEL_SIZE - 1;
    localparam int LINE_W = LINES * RGB_W;
    localparam int NTAP = KERNEL_SIZE * KERNEL_SIZE;

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             col_last;
    logic             row_last;
    logic             win_full;

    logic             s1_valid_reg;
    logic [RGB_W-1:0] s1_pix_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic             s1_result_reg;
    logic             s1_last_reg;
    logic             s1_fwd_reg;
    logic [LINE_W-1:0] fwd_data_reg;

    logic [LINE_W-1:0]                  ram_rd_data;
    logic [LINES-1:0][RGB_W-1:0]        line_rd;
    logic [KERNEL_SIZE-1:0][RGB_W-1:0]  colv;
    logic [LINE_W-1:0]                  line_wr;

    logic [NTAP-1:0][RGB_W-1:0] win_reg;
    logic                       win_valid_reg;
    logic                       win_result_reg;
    logic                       win_last_reg;

    assign col_last = (DIM_W'(col_reg) + DIM_W'(1)) >= eff_width;
    assign row_last = (DIM_W'(row_reg) + DIM_W'(1)) >= eff_height;
    assign win_full = (col_reg >= COL_W'(KERNEL_SIZE - 1)) &&
                      (row_reg >= ROW_W'(KERNEL_SIZE - 1));

    always_comb begin
        col_next = col_reg + COL_W'(1);
        row_next = row_reg;
        if (col_last) begin
            col_next = '0;
            row_next = row_last ? '0 : row_reg + ROW_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= in_valid;
            if (in_valid) begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

    // A line entry written by the previous pixel is not yet visible to a read in the
    // same cycle, so that write data is carried along instead.
    always_ff @(posedge aclk) begin
        if (in_valid) begin
            s1_pix_reg <= in_pix;
            s1_col_reg <= col_reg;
            s1_result_reg <= win_full;
            s1_last_reg <= col_last && row_last;
            s1_fwd_reg <= s1_valid_reg && (s1_col_reg == col_reg);
            fwd_data_reg <= line_wr;
        end
    end

    gbw_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .aclk    (aclk),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_col_reg),
        .wr_data (line_wr),
        .rd_en   (in_valid),
        .rd_addr (col_reg),
        .rd_data (ram_rd_data)
    );

    assign line_rd = s1_fwd_reg ? fwd_data_reg : ram_rd_data;
    assign colv = {s1_pix_reg, line_rd};
    assign line_wr = colv[KERNEL_SIZE-1:1];

    always_ff @(posedge aclk) begin
        if (s1_valid_reg) begin
            for (int r = 0; r < KERNEL_SIZE; r++) begin
                for (int c = 0; c < KERNEL_SIZE - 1; c++) begin
                    win_reg[r*KERNEL_SIZE+c] <= win_reg[r*KERNEL_SIZE+c+1];
                end
                win_reg[r*KERNEL_SIZE+KERNEL_SIZE-1] <= colv[r];
            end
            win_result_reg <= s1_result_reg;
            win_last_reg <= s1_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_valid_reg <= 1'b0;
        end else begin
            win_valid_reg <= s1_valid_reg;
        end
    end

    assign win = win_reg;
    assign win_ctrl = '{valid: win_valid_reg, result: win_result_reg, last: win_last_reg};

endmodule

`default_nettype wire

// ===== rtl/gbw_filter.sv =====
`default_nettype none

module gbw_filter
    import gbw_pkg::*;
#(
    parameter int KERNEL_SIZE = 5,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic [KERNEL_SIZE*KERNEL_SIZE-1:0][RGB_W-1:0] win,
    input  gbw_ctrl_t                                     ctrl_in,
    output logic [RGB_W-1:0]                              rgb_out,
    output gbw_ctrl_t                                     ctrl_out
);

    localparam int NTAP = KERNEL_SIZE * KERNEL_SIZE;
    localparam int LVL = $clog2(NTAP);
    localparam int NLEAF = 1 << LVL;
    localparam int NNODE = 2 * NLEAF - 1;
    localparam int W_W = WEIGHT_BITS + 1;
    localparam int PROD_W = PIX_W + W_W;
    localparam int ACC_W = WEIGHT_BITS + PIX_W + 1;

    // Each channel has a binary adder tree kept as a heap: node n sums nodes 2n+1 and
    // 2n+2, the leaves hold the weighted taps, and every node is a register.
    logic [ACC_W-1:0] node_reg [NUM_CH][NNODE];
    gbw_ctrl_t        cq_reg [LVL+1];
    gbw_ctrl_t        out_ctrl_reg;
    logic [RGB_W-1:0] rgb_reg;

    for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_ch
        for (genvar n = 0; n < NLEAF - 1; n++) begin : g_node
            always_ff @(posedge aclk) begin
                node_reg[ch][n] <= node_reg[ch][2*n+1] + node_reg[ch][2*n+2];
            end
        end
        for (genvar l = 0; l < NLEAF; l++) begin : g_leaf
            if (l < NTAP) begin : g_tap
                localparam logic [W_W-1:0] WT = W_W'(gbw_weight(KERNEL_SIZE, WEIGHT_BITS,
                                                                 l / KERNEL_SIZE,
                                                                 l % KERNEL_SIZE));
                always_ff @(posedge aclk) begin
                    node_reg[ch][NLEAF-1+l] <=
                        ACC_W'(PROD_W'(win[l][ch*PIX_W +: PIX_W]) * PROD_W'(WT));
                end
            end else begin : g_pad
                always_ff @(posedge aclk) begin
                    node_reg[ch][NLEAF-1+l] <= '0;
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (node_reg[ch][0][ACC_W-1:WEIGHT_BITS+PIX_W] != '0) begin
                rgb_reg[ch*PIX_W +: PIX_W] <= '1;
            end else begin
                rgb_reg[ch*PIX_W +: PIX_W] <= node_reg[ch][0][WEIGHT_BITS +: PIX_W];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= LVL; k++) begin
                cq_reg[k] <= '0;
            end
            out_ctrl_reg <= '0;
        end else begin
            cq_reg[0] <= ctrl_in;
            for (int k = 1; k <= LVL; k++) begin
                cq_reg[k] <= cq_reg[k-1];
            end
            out_ctrl_reg <= cq_reg[LVL];
        end
    end

    assign rgb_out = rgb_reg;
    assign ctrl_out = out_ctrl_reg;

endmodule

`default_nettype wire

// ===== rtl/gbw_fifo.sv =====
`default_nettype none

module gbw_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pop;

    assign out_valid = count_reg != '0;
    assign out_data = mem_reg[rd_ptr_reg];
    assign pop = out_valid && out_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== tb/gbw_blur_checker.sv =====
`timescale 1ns / 100ps

module gbw_blur_checker
    import gbw_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [RGB_W-1:0]       s_tdata,    // red_in, green_in, blue_in

    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [RGB_W-1:0]       m_tdata,    // red_out, green_out, blue_out
    input  logic                   m_tlast,    // frame_done

    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,

    output int                     fail_count,
    output int                     backlog
);

    localparam int KSIZE = 5;
    localparam int KMID = KSIZE / 2;
    localparam int LINE_DEPTH = 1024;
    localparam int FRAC_BITS = 16;

    typedef struct packed {
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] red;
    } rgb_t;

    typedef struct {
        rgb_t pix;
        logic frame_end;
    } blur_result_t;

    rgb_t                line_mem [0:KSIZE-2][0:LINE_DEPTH-1];
    rgb_t                win [0:KSIZE-1][0:KSIZE-1];
    int unsigned         gauss_w [0:KSIZE-1][0:KSIZE-1];
    int unsigned         col_pos;
    int unsigned         row_pos;
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    blur_result_t        blurred_q [$];

    function automatic longint unsigned gauss_profile(input int d);
        longint unsigned v;
        case (d)
            0: v = 64'd16777216;
            1: v = 64'd14805841;
            2: v = 64'd10175896;
            default: v = 64'd5446765;
        endcase
        return v;
    endfunction

    // Each weight is the product of two Q0.24 profile taps divided by their grand total,
    // rounded to Q0.16. The center tap absorbs the rounding error.
    function automatic void build_gauss_kernel();
        longint unsigned prof [0:KSIZE-1];
        logic [127:0]    total;
        logic [127:0]    quot;
        longint unsigned wsum;
        int              i;
        int              j;
        total = '0;
        wsum = 0;
        for (i = 0; i < KSIZE; i++) begin
            prof[i] = gauss_profile((i > KMID) ? i - KMID : KMID - i);
        end
        for (i = 0; i < KSIZE; i++) begin
            for (j = 0; j < KSIZE; j++) begin
                total = total + 128'(prof[i] * prof[j]);
            end
        end
        for (i = 0; i < KSIZE; i++) begin
            for (j = 0; j < KSIZE; j++) begin
                quot = ((128'(prof[i]) * 128'(prof[j])) << (FRAC_BITS + 1)) / total;
                gauss_w[i][j] = 32'((quot + 128'd1) >> 1);
                wsum = wsum + gauss_w[i][j];
            end
        end
        gauss_w[KMID][KMID] = 32'(longint'(gauss_w[KMID][KMID])
                                  + (longint'(1) << FRAC_BITS) - longint'(wsum));
    endfunction

    task automatic clear_predictor();
        int y;
        int x;
        width_reg = WIDTH_RESET;
        height_reg = HEIGHT_RESET;
        col_pos = 0;
        row_pos = 0;
        for (y = 0; y < KSIZE; y++) begin
            for (x = 0; x < KSIZE; x++) begin
                win[y][x] = '0;
            end
        end
        blurred_q.delete();
    endtask

    task automatic take_pixel(input rgb_t px);
        int unsigned  eff_w;
        int unsigned  eff_h;
        int unsigned  c;
        int unsigned  r;
        int unsigned  acc;
        int           y;
        int           x;
        int           ch;
        rgb_t         colv [0:KSIZE-1];
        blur_result_t res;
        logic         in_window;
        logic         at_end;

        eff_w = width_reg;
        if (eff_w > LINE_DEPTH) eff_w = LINE_DEPTH;
        if (eff_w == 0) eff_w = 1;
        eff_h = height_reg;
        if (eff_h > HEIGHT_LIMIT) eff_h = HEIGHT_LIMIT;
        if (eff_h == 0) eff_h = 1;
        c = (col_pos >= LINE_DEPTH) ? LINE_DEPTH - 1 : col_pos;
        r = row_pos;

        for (y = 0; y < KSIZE - 1; y++) begin
            colv[y] = line_mem[y][c];
        end
        colv[KSIZE-1] = px;
        for (y = 0; y < KSIZE - 1; y++) begin
            line_mem[y][c] = colv[y+1];
        end
        for (y = 0; y < KSIZE; y++) begin
            for (x = 0; x < KSIZE - 1; x++) begin
                win[y][x] = win[y][x+1];
            end
            win[y][KSIZE-1] = colv[y];
        end

        in_window = (c >= KSIZE - 1) && (r >= KSIZE - 1);
        at_end = (c + 1 >= eff_w) && (r + 1 >= eff_h);
        if (c + 1 >= eff_w) begin
            col_pos = 0;
            row_pos = (r + 1 >= eff_h) ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
        end

        if (in_window) begin
            res.pix = '0;
            for (ch = 0; ch < NUM_CH; ch++) begin
                acc = 0;
                for (y = 0; y < KSIZE; y++) begin
                    for (x = 0; x < KSIZE; x++) begin
                        acc = acc + gauss_w[y][x] * 32'(PIX_W'(win[y][x] >> (PIX_W * ch)));
                    end
                end
                acc = acc >> FRAC_BITS;
                if (acc > 255) acc = 255;
                case (ch)
                    0: res.pix.red = PIX_W'(acc);
                    1: res.pix.green = PIX_W'(acc);
                    default: res.pix.blue = PIX_W'(acc);
                endcase
            end
            res.frame_end = at_end;
            blurred_q.push_back(res);
        end
    endtask

    function automatic void check_field(input string what, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            fail_count++;
        end
    endfunction

    task automatic check_result();
        blur_result_t want;
        rgb_t         got;
        got = m_tdata;
        if (blurred_q.size() == 0) begin
            $display("%0t: unexpected result, expected none, got r=%0d g=%0d b=%0d last=%0b",
                     $time, got.red, got.green, got.blue, m_tlast);
            fail_count++;
        end else begin
            want = blurred_q.pop_front();
            check_field("red_out", want.pix.red, got.red);
            check_field("green_out", want.pix.green, got.green);
            check_field("blue_out", want.pix.blue, got.blue);
            check_field("frame_done", want.frame_end, m_tlast);
        end
    endtask

    initial begin
        fail_count = 0;
        backlog = 0;
        build_gauss_kernel();
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_predictor();
        end else begin
            if (m_tvalid && m_tready) begin
                check_result();
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_IMAGE_WIDTH) begin
                    width_reg = cfg_data[WIDTH_W-1:0];
                end else if (cfg_index == REG_IMAGE_HEIGHT) begin
                    height_reg = cfg_data[HEIGHT_W-1:0];
                end
            end
            if (s_tvalid && s_tready) begin
                take_pixel(s_tdata);
            end
        end
        backlog <= blurred_q.size();
    end

endmodule

// ===== tb/gaussian_blur_rgb_window_tb.sv =====
`timescale 1ns / 100ps

module gaussian_blur_rgb_window_tb;
    import gbw_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 16;

    typedef enum int {
        FILL_RANDOM,
        FILL_EXTREME,
        FILL_FLAT,
        FILL_WHITE
    } fill_e;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [RGB_W-1:0]       s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [RGB_W-1:0]       m_tdata;
    logic                   m_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_IMAGE_WIDTH;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    int                     fail_count;
    int                     backlog;
    int unsigned            snd_idle_pct = 34;
    int unsigned            rcv_idle_pct = 61;
    int unsigned            cycle_cnt = 0;

    always #4 aclk = ~aclk;

    gaussian_blur_rgb_window u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    gbw_blur_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .backlog    (backlog)
    );

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= rcv_idle_pct);
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("gaussian_blur_rgb_window_tb failed");
            $finish;
        end
    end

    task automatic send_pixel(input logic [RGB_W-1:0] px);
        while ($urandom_range(99) < snd_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= px;
        @(negedge aclk);
        while (!s_tready) @(negedge aclk);
        @(posedge aclk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (backlog != 0) @(posedge aclk);
    endtask

    // Pixels that make no result may still be in flight once the last result is out.
    task automatic settle();
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge aclk);
        while (!cfg_ready) @(negedge aclk);
        @(posedge aclk);
    endtask

    task automatic set_geometry(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_frame(input int unsigned npix, input fill_e fill);
        int unsigned      i;
        logic [RGB_W-1:0] px;
        logic [PIX_W-1:0] flat;
        logic [2:0]       pick;
        flat = ($urandom_range(1) == 1) ? '1 : '0;
        for (i = 0; i < npix; i++) begin
            pick = 3'($urandom);
            case (fill)
                FILL_RANDOM: px = RGB_W'($urandom);
                FILL_EXTREME: px = {{PIX_W{pick[2]}}, {PIX_W{pick[1]}}, {PIX_W{pick[0]}}};
                FILL_FLAT: px = {NUM_CH{flat}};
                default: px = '1;
            endcase
            if (i != 0 && $urandom_range(499) == 0) begin
                drain_results();
            end
            send_pixel(px);
        end
    endtask

    task automatic random_frames(input int unsigned target);
        int unsigned sent;
        int unsigned w;
        int unsigned h;
        int unsigned npix;
        int unsigned reps;
        int unsigned sel;
        int unsigned r;
        fill_e       fill;
        sent = 0;
        while (sent < target) begin
            sel = $urandom_range(19);
            if (sel == 0) begin
                w = $urandom_range(4);
            end else if (sel < 4) begin
                w = $urandom_range(13, 48);
            end else begin
                w = $urandom_range(5, 12);
            end
            h = (sel == 1) ? $urandom_range(4) : $urandom_range(5, 8);
            npix = ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h);
            settle();
            set_geometry({2'($urandom), 11'(w)}, 13'(h));
            reps = $urandom_range(1, 3);
            repeat (reps) begin
                r = $urandom_range(7);
                fill = (r < 5) ? FILL_RANDOM : ((r < 7) ? FILL_EXTREME : FILL_FLAT);
                send_frame(npix, fill);
            end
            sent += reps * npix;
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // One full row at the reset geometry, then a short last row closes the frame.
        send_frame(640, FILL_RANDOM);
        settle();
        set_geometry(13'd5, 13'd2);
        send_frame(5, FILL_RANDOM);

        settle();
        set_geometry({2'b11, 11'd5}, 13'd5);
        send_frame(25, FILL_WHITE);
        settle();
        set_geometry(13'd0, 13'd3);
        send_frame(3, FILL_RANDOM);
        settle();
        set_geometry(13'd4, 13'd7);
        send_frame(28, FILL_EXTREME);
        settle();
        set_geometry(13'd6, 13'd4);
        send_frame(24, FILL_RANDOM);
        settle();
        set_geometry(13'd7, 13'd0);
        send_frame(7, FILL_RANDOM);

        settle();
        snd_idle_pct = 61;
        rcv_idle_pct = 34;
        random_frames(80);

        settle();
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        set_geometry(13'h1FFF, 13'd1);
        send_frame(1024, FILL_RANDOM);
        settle();
        set_geometry(13'd5, 13'h1FFF);
        send_frame(25, FILL_RANDOM);
        settle();
        write_reg(REG_IMAGE_HEIGHT, 13'd6);
        cfg_valid <= 1'b0;
        send_frame(5, FILL_RANDOM);
        random_frames(30);

        settle();
        if (fail_count == 0) begin
            $display("gaussian_blur_rgb_window_tb passed");
        end else begin
            $display("gaussian_blur_rgb_window_tb failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/gbw_pkg.sv
rtl/gbw_ram.sv
rtl/gbw_window.sv
rtl/gbw_filter.sv
rtl/gbw_fifo.sv
rtl/gaussian_blur_rgb_window.sv
tb/gbw_blur_checker.sv
tb/gaussian_blur_rgb_window_tb.sv
